// ===== hw/rtl/htrie_pkg.sv =====
// Shared types and constants for the hashed trie block.
// Holds the controller/datapath command and status structs and the result codes.
// No dependencies.
package htrie_pkg;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int CFG_W       = 11;
    localparam int CFG_RESET   = 1024;
    localparam int HASH_NODE_K = 17;
    localparam int HASH_SYM_K  = 13;
    localparam int SYM_W       = 8;
    localparam int END_W       = 10;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic div_step;
        logic head_rd;
        logic take_head;
        logic ent_rd;
        logic follow;
        logic next_link;
        logic alloc;
        logic fail;
        logic final_rd;
        logic emit;
    } htrie_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic failed;
        logic e_zero;
        logic match;
        logic lookup;
        logic last;
        logic pool_full;
        logic out_full;
    } htrie_sts_t;

endpackage

// ===== hw/rtl/htrie_dp.sv =====
// Datapath of the hashed trie: bucket heads, transition entries, final marks,
// the bit-serial hash remainder unit and the result register.
// Depends on htrie_pkg; driven by htrie_ctrl.
module htrie_dp #(
    parameter int NODES   = 1024,
    parameter int BUCKETS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  htrie_pkg::htrie_cmd_t     cmd,
    output htrie_pkg::htrie_sts_t     sts,
    input  logic                      in_op,
    input  logic [htrie_pkg::SYM_W-1:0] in_sym,
    input  logic                      in_last,
    input  logic                      cfg_we,
    input  logic [htrie_pkg::CFG_W-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_status,
    output logic [htrie_pkg::END_W-1:0] out_end_node
);

    localparam int NW  = $clog2(NODES);
    localparam int BW  = $clog2(BUCKETS);
    localparam int MW  = BW + 1;
    localparam int DW  = ((NW + 5 > 12) ? NW + 5 : 12) + 1;
    localparam int CW  = $clog2(DW + 1);
    localparam int EW  = NW + htrie_pkg::SYM_W + NW;

    logic [htrie_pkg::CFG_W-1:0] cfg_reg;
    logic [NW-1:0]               cur_reg;
    logic [NW:0]                 free_reg;
    logic                        failed_reg;
    logic                        op_reg;
    logic                        last_reg;
    logic [htrie_pkg::SYM_W-1:0] sym_reg;
    logic [DW-1:0]               div_reg;
    logic [MW-1:0]               rem_reg;
    logic [CW-1:0]               cnt_reg;
    logic [NW-1:0]               e_reg;
    logic [BW-1:0]               clr_reg;
    logic                        ov_reg;
    logic [1:0]                  ost_reg;
    logic [htrie_pkg::END_W-1:0] oend_reg;

    logic [NW-1:0] head_mem [BUCKETS];
    logic [EW-1:0] ent_mem [NODES];
    logic          fin_mem [NODES];
    logic [NW-1:0] head_q;
    logic [EW-1:0] ent_q;
    logic          fin_q;

    logic [MW-1:0] meff;
    logic [MW:0]   trial;
    logic [DW-1:0] dividend;
    logic [BW-1:0] bucket;
    logic [NW-1:0] new_node;
    logic [NW-1:0] ent_start;
    logic [htrie_pkg::SYM_W-1:0] ent_letter;
    logic [NW-1:0] ent_link;

    always_comb
    begin
        if (cfg_reg == '0)
            meff = MW'(1);
        else if (32'(cfg_reg) > 32'(BUCKETS))
            meff = MW'(BUCKETS);
        else
            meff = MW'(cfg_reg);
    end

    assign trial    = {rem_reg, div_reg[DW-1]};
    assign dividend = DW'({cur_reg, 4'b0000}) + DW'(cur_reg)
                    + DW'(in_sym) * DW'(htrie_pkg::HASH_SYM_K);
    assign bucket   = rem_reg[BW-1:0];
    assign new_node = free_reg[NW-1:0];
    assign ent_start  = ent_q[EW-1 -: NW];
    assign ent_letter = ent_q[NW +: htrie_pkg::SYM_W];
    assign ent_link   = ent_q[NW-1:0];

    assign sts.clr_done  = (clr_reg == BW'(BUCKETS - 1));
    assign sts.div_done  = (cnt_reg == CW'(DW - 1));
    assign sts.failed    = failed_reg;
    assign sts.e_zero    = (e_reg == '0);
    assign sts.match     = (ent_start == cur_reg) && (ent_letter == sym_reg);
    assign sts.lookup    = (op_reg == htrie_pkg::OP_LOOKUP);
    assign sts.last      = last_reg;
    assign sts.pool_full = (free_reg == (NW + 1)'(NODES));
    assign sts.out_full  = ov_reg;

    // Memories: registered reads, single write per port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            head_mem[clr_reg] <= '0;
        else if (cmd.alloc)
            head_mem[bucket] <= new_node;
        if (cmd.head_rd)
            head_q <= head_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
            ent_mem[new_node] <= {cur_reg, sym_reg, head_q};
        if (cmd.ent_rd)
            ent_q <= ent_mem[e_reg];
    end

    // A new node starts with its final mark cleared, so no sweep is needed here.
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
            fin_mem[new_node] <= 1'b0;
        else if (cmd.emit && !failed_reg && op_reg == htrie_pkg::OP_INSERT)
            fin_mem[cur_reg] <= 1'b1;
        if (cmd.final_rd)
            fin_q <= fin_mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= htrie_pkg::CFG_W'(htrie_pkg::CFG_RESET);
            cur_reg    <= '0;
            free_reg   <= (NW + 1)'(1);
            failed_reg <= 1'b0;
            clr_reg    <= '0;
            ov_reg     <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_data;
            if (cmd.clear_wr)
                clr_reg <= clr_reg + BW'(1);
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.follow)
                cur_reg <= e_reg;
            else if (cmd.alloc)
                cur_reg <= new_node;
            else if (cmd.emit)
                cur_reg <= '0;
            if (cmd.alloc)
                free_reg <= free_reg + (NW + 1)'(1);
            if (cmd.fail)
                failed_reg <= 1'b1;
            else if (cmd.emit)
                failed_reg <= 1'b0;
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            sym_reg  <= in_sym;
            last_reg <= in_last;
            div_reg  <= dividend;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_reg << 1;
            if (trial >= {1'b0, meff})
                rem_reg <= MW'(trial - {1'b0, meff});
            else
                rem_reg <= MW'(trial);
        end
        if (cmd.take_head)
            e_reg <= head_q;
        else if (cmd.next_link)
            e_reg <= ent_link;
        if (cmd.emit)
        begin
            if (failed_reg)
            begin
                ost_reg  <= sts.lookup ? htrie_pkg::ST_ABSENT : htrie_pkg::ST_FULL;
                oend_reg <= '0;
            end
            else
            begin
                if (sts.lookup)
                    ost_reg <= fin_q ? htrie_pkg::ST_FOUND : htrie_pkg::ST_ABSENT;
                else
                    ost_reg <= htrie_pkg::ST_INSERTED;
                oend_reg <= htrie_pkg::END_W'(cur_reg);
            end
        end
    end

    assign out_valid    = ov_reg;
    assign out_status   = ost_reg;
    assign out_end_node = oend_reg;

endmodule

// ===== hw/rtl/htrie_ctrl.sv =====
// Controller state machine of the hashed trie: clearing sweep, hash,
// chain walk, allocation and result sequencing.
// Depends on htrie_pkg; drives htrie_dp.
module htrie_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  htrie_pkg::htrie_sts_t sts,
    output htrie_pkg::htrie_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_HASH, S_HEAD_RD, S_HEAD_WAIT,
        S_WALK, S_ENT_WAIT, S_FIN, S_FWAIT, S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
                state_next = sts.failed ? S_FIN : S_HASH;
            S_HASH:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                cmd.take_head = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (sts.e_zero)
                begin
                    // End of chain without a match.
                    if (sts.lookup || sts.pool_full)
                        cmd.fail = 1'b1;
                    else
                        cmd.alloc = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_ENT_WAIT;
                end
            end
            S_ENT_WAIT:
            begin
                if (sts.match)
                begin
                    cmd.follow = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.next_link = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_FIN:
            begin
                if (!sts.last)
                    state_next = S_IDLE;
                else if (sts.lookup && !sts.failed)
                begin
                    cmd.final_rd = 1'b1;
                    state_next   = S_FWAIT;
                end
                else
                    state_next = S_EMIT;
            end
            S_FWAIT:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/hashed_trie_insert_lookup.sv =====
// Hashed trie insert/lookup, one word byte per transaction.
// Each byte runs the bit-serial bucket remainder over a DW-bit dividend, DW = max(clog2(NODES)+5,12)+1
// (16 at the defaults), then walks the bucket's chain entries; last bytes then sequence a result.
// One byte is in work at a time; the hash remainder unit and the chain walk set the rate, and a
// result not yet taken holds the next last byte. Bytes of a failed word skip the hash and the walk.
// After reset an internal sweep clears BUCKETS bucket heads, one per cycle, before the
// first transaction is taken; configuration writes are taken at all times.
module hashed_trie_insert_lookup #(
    parameter int NODES   = 1024,
    parameter int BUCKETS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] op, [8:1] symbol, [15:9] zero
    input  logic        s_axis_tlast,   // last_symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] status, [11:2] end_node, [15:12] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data        // hash_modulus
);

    htrie_pkg::htrie_cmd_t cmd;
    htrie_pkg::htrie_sts_t sts;
    logic [1:0]            res_status;
    logic [9:0]            res_end;

    assign cfg_ready = 1'b1;

    htrie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    htrie_dp #(
        .NODES   (NODES),
        .BUCKETS (BUCKETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_op        (s_axis_tdata[0]),
        .in_sym       (s_axis_tdata[8:1]),
        .in_last      (s_axis_tlast),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (res_status),
        .out_end_node (res_end)
    );

    assign m_axis_tdata = {4'b0000, res_end, res_status};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the hashed trie insert/lookup block.
// Runs a directed table, then random words across several hash moduli, a pool fill and a mix.
// Depends on htrie_pkg and hashed_trie_insert_lookup.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_NODES   = 1024;
    localparam int NUM_BUCKETS = 1024;

    typedef struct packed {
        logic       op;
        logic [7:0] sym;
        logic       last;
        logic       typed;
        logic [1:0] status;
        logic [9:0] node;
    } byte_row_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] node;
    } trie_result_t;

    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][7:0] text;
    } word_t;

    // Directed words; the typed rows carry results that follow directly from the allocation order.
    localparam byte_row_t DIRECTED [21] = '{
        '{htrie_pkg::OP_LOOKUP, 8'h41, 1'b1, 1'b1, htrie_pkg::ST_ABSENT,   10'd0},
        '{htrie_pkg::OP_INSERT, 8'h00, 1'b1, 1'b1, htrie_pkg::ST_INSERTED, 10'd1},
        '{htrie_pkg::OP_INSERT, 8'hFF, 1'b1, 1'b1, htrie_pkg::ST_INSERTED, 10'd2},
        '{htrie_pkg::OP_LOOKUP, 8'h00, 1'b1, 1'b1, htrie_pkg::ST_FOUND,    10'd1},
        '{htrie_pkg::OP_LOOKUP, 8'hFF, 1'b1, 1'b1, htrie_pkg::ST_FOUND,    10'd2},
        '{htrie_pkg::OP_INSERT, 8'h41, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_INSERT, 8'h42, 1'b1, 1'b1, htrie_pkg::ST_INSERTED, 10'd4},
        '{htrie_pkg::OP_LOOKUP, 8'h41, 1'b1, 1'b1, htrie_pkg::ST_ABSENT,   10'd3},
        '{htrie_pkg::OP_LOOKUP, 8'h41, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_LOOKUP, 8'h42, 1'b1, 1'b1, htrie_pkg::ST_FOUND,    10'd4},
        '{htrie_pkg::OP_LOOKUP, 8'h43, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_LOOKUP, 8'h42, 1'b1, 1'b1, htrie_pkg::ST_ABSENT,   10'd0},
        '{htrie_pkg::OP_LOOKUP, 8'h43, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_INSERT, 8'h42, 1'b1, 1'b1, htrie_pkg::ST_FULL,     10'd0},
        '{htrie_pkg::OP_INSERT, 8'h41, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_LOOKUP, 8'h42, 1'b1, 1'b1, htrie_pkg::ST_FOUND,    10'd4},
        '{htrie_pkg::OP_INSERT, 8'h50, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_LOOKUP, 8'h51, 1'b1, 1'b1, htrie_pkg::ST_ABSENT,   10'd0},
        '{htrie_pkg::OP_INSERT, 8'h50, 1'b0, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_INSERT, 8'h51, 1'b1, 1'b0, htrie_pkg::ST_INSERTED, 10'd0},
        '{htrie_pkg::OP_INSERT, 8'h7F, 1'b1, 1'b0, htrie_pkg::ST_INSERTED, 10'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    // Trie shadow state.
    int unsigned modulus;
    int unsigned walk_node;
    int unsigned free_node;
    bit          walk_failed;
    int unsigned head_of   [NUM_BUCKETS];
    int unsigned from_node [NUM_NODES];
    int unsigned letter_of [NUM_NODES];
    int unsigned link_of   [NUM_NODES];
    bit          is_final  [NUM_NODES];

    trie_result_t pending_results[$];
    word_t        known_words[$];
    int           mismatches;
    bit           send_idle;
    bit           recv_idle;

    hashed_trie_insert_lookup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the shadow trie by one byte; returns 1 when the byte ends a word.
    function automatic bit trie_advance(input logic op, input logic [7:0] sym,
                                        input logic last, output trie_result_t res);
        int unsigned m;
        int unsigned bkt;
        int unsigned e;
        int unsigned hit;
        int unsigned steps;
        res = '0;
        if (!walk_failed)
        begin
            m = (modulus == 0) ? 1 : ((modulus > NUM_BUCKETS) ? NUM_BUCKETS : modulus);
            bkt = (walk_node * htrie_pkg::HASH_NODE_K + sym * htrie_pkg::HASH_SYM_K) % m;
            e = head_of[bkt];
            hit = 0;
            steps = 0;
            while (e != 0 && steps < NUM_NODES && hit == 0)
            begin
                if (from_node[e] == walk_node && letter_of[e] == sym)
                    hit = e;
                else
                    e = link_of[e];
                steps++;
            end
            if (hit != 0)
                walk_node = hit;
            else if (op == htrie_pkg::OP_LOOKUP || free_node >= NUM_NODES)
                walk_failed = 1'b1;
            else
            begin
                from_node[free_node] = walk_node;
                letter_of[free_node] = sym;
                link_of[free_node] = head_of[bkt];
                head_of[bkt] = free_node;
                walk_node = free_node;
                free_node++;
            end
        end
        if (!last)
            return 1'b0;
        if (walk_failed)
            res.status = (op == htrie_pkg::OP_LOOKUP) ? htrie_pkg::ST_ABSENT : htrie_pkg::ST_FULL;
        else if (op == htrie_pkg::OP_LOOKUP)
        begin
            res.status = is_final[walk_node] ? htrie_pkg::ST_FOUND : htrie_pkg::ST_ABSENT;
            res.node = walk_node[9:0];
        end
        else
        begin
            is_final[walk_node] = 1'b1;
            res.status = htrie_pkg::ST_INSERTED;
            res.node = walk_node[9:0];
        end
        walk_node = 0;
        walk_failed = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic op, input logic [7:0] sym, input logic last,
                             input bit typed, input trie_result_t typed_res);
        int gap;
        trie_result_t res;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, sym, op};
        s_axis_tlast  <= last;
        if (trie_advance(op, sym, last, res))
            pending_results.push_back(typed ? typed_res : res);
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic send_word(input word_t w, input logic op, input bit mixed);
        logic byte_op;
        for (int i = 0; i < w.len; i++)
        begin
            byte_op = mixed ? logic'($urandom_range(0, 1)) : op;
            send_byte(byte_op, w.text[i], i == w.len - 1, 1'b0, '0);
        end
    endtask

    // Waits until the block has drained, then writes the modulus.
    task automatic write_modulus(input logic [10:0] value);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        modulus = value;
    endtask

    function automatic word_t random_word();
        word_t w;
        bit narrow;
        w.len = 4'($urandom_range(1, 6));
        narrow = ($urandom_range(0, 1) == 1);
        for (int i = 0; i < 8; i++)
            w.text[i] = narrow ? 8'($urandom_range(8'h61, 8'h64)) : 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic random_words(input int count, input int insert_pct);
        word_t w;
        bit mixed;
        logic op;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_idle = ~send_idle;
            mixed = ($urandom_range(0, 19) == 0);
            op = ($urandom_range(1, 100) <= insert_pct) ? htrie_pkg::OP_INSERT
                                                        : htrie_pkg::OP_LOOKUP;
            if (op == htrie_pkg::OP_LOOKUP && known_words.size() > 0
                && $urandom_range(0, 9) < 7)
            begin
                w = known_words[$urandom_range(0, known_words.size() - 1)];
                // Sometimes look up only a prefix of a stored word.
                if ($urandom_range(0, 3) == 0 && w.len > 1)
                    w.len = 4'($urandom_range(1, w.len - 1));
            end
            else
                w = random_word();
            if (op == htrie_pkg::OP_INSERT && !mixed)
            begin
                if (known_words.size() >= 64)
                    void'(known_words.pop_front());
                known_words.push_back(w);
            end
            send_word(w, op, mixed);
        end
    endtask

    // Result checker; values are stable at the falling edge ahead of the accepting edge.
    always @(negedge clk)
    begin
        trie_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result tdata=%h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[11:2] !== want.node)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result status/end_node exp %0d/%0d got %0d/%0d",
                                 want.status, want.node, m_axis_tdata[1:0], m_axis_tdata[11:2]);
                end
            end
        end
    end

    // Result receiver with random back-pressure.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_idle = ~recv_idle;
            stall = recv_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge clk); while (!m_axis_tvalid);
            @(posedge clk);
        end
    end

    initial
    begin
        #50000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        trie_result_t typed_res;
        logic [10:0] settings [6];
        settings      = '{11'd1, 11'd0, 11'd2047, 11'd7, 11'd1000, 11'd1024};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        mismatches    = 0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;
        modulus       = htrie_pkg::CFG_RESET;
        walk_node     = 0;
        free_node     = 1;
        walk_failed   = 1'b0;
        for (int i = 0; i < NUM_NODES; i++)
        begin
            head_of[i]   = 0;
            from_node[i] = 0;
            letter_of[i] = 0;
            link_of[i]   = 0;
            is_final[i]  = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            typed_res.status = DIRECTED[i].status;
            typed_res.node   = DIRECTED[i].node;
            send_byte(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].last,
                      DIRECTED[i].typed, typed_res);
        end

        foreach (settings[i])
        begin
            write_modulus(settings[i]);
            random_words(10, 55);
        end

        // Fill the node pool, then keep inserting and looking up against a full pool.
        while (free_node < NUM_NODES)
            random_words(1, 100);
        random_words(15, 50);
        write_modulus(11'd300);
        random_words(10, 50);

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/htrie_pkg.sv
hw/rtl/htrie_dp.sv
hw/rtl/htrie_ctrl.sv
hw/rtl/hashed_trie_insert_lookup.sv
tb/tb_top.sv
